// ===== rtl/core/cmef_pkg.sv =====
// Shared types and constants for the component merge edge filter.
`timescale 1ns / 1ps

package cmef_pkg;

	// Default size of the label ring
	localparam int MAX_CELLS_DEF = 1024;

	// Field widths
	localparam int CFG_W  = 6;
	localparam int CELL_W = 10;

	// Register map: index taken from paddr[2]
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	// Register reset values
	localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 6'd32;
	localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 6'd32;

	// Command codes
	localparam logic CMD_CLEAR = 1'b0;
	localparam logic CMD_EDGE  = 1'b1;

	// Status codes
	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_RANGE = 1'b1;

	// Controls from the sequencer to the ring of label cells
	typedef struct packed {
		logic shift;
		logic clear;
	} ring_ctl_t;

endpackage

// ===== rtl/core/cmef_cell.sv =====
// One label cell of the rotating label ring.
`timescale 1ns / 1ps

module cmef_cell #(
	parameter int LW    = 10,
	parameter int INDEX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmef_pkg::ring_ctl_t ring_ctl,
	input  logic [LW-1:0]       lbl_in,
	output logic [LW-1:0]       lbl_out
);

	logic [LW-1:0] lbl_q;

	// Clear loads own index; shift takes the neighbor's label
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbl_q <= LW'(INDEX);
		end else if (ring_ctl.clear) begin
			lbl_q <= LW'(INDEX);
		end else if (ring_ctl.shift) begin
			lbl_q <= lbl_in;
		end
	end

	assign lbl_out = lbl_q;

endmodule

// ===== rtl/core/cmef_ctrl.sv =====
// Sequencer: clear, range check, label lookup pass, relabel pass and result word.
`timescale 1ns / 1ps

module cmef_ctrl #(
	parameter int MAX_CELLS = cmef_pkg::MAX_CELLS_DEF,
	parameter int LW        = $clog2(MAX_CELLS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         command,
	input  logic [cmef_pkg::CELL_W-1:0]  first_cell,
	input  logic [cmef_pkg::CELL_W-1:0]  second_cell,
	input  logic [cmef_pkg::CFG_W-1:0]   grid_width,
	input  logic [cmef_pkg::CFG_W-1:0]   grid_height,
	input  logic [LW-1:0]                head_lbl,
	output logic [LW-1:0]                tail_lbl,
	output cmef_pkg::ring_ctl_t          ring_ctl,
	output logic                         busy,
	output logic                         done,
	output logic                         accepted,
	output logic [cmef_pkg::CELL_W-1:0]  merged_label,
	output logic                         status
);

	localparam int CFW = cmef_pkg::CFG_W;
	localparam int CLW = cmef_pkg::CELL_W;
	localparam int CW  = $clog2(MAX_CELLS + 1);
	localparam int NW  = (CW > 2 * CFW) ? CW : 2 * CFW;
	localparam int XW  = (LW > CLW) ? LW : CLW;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_FIND    = 2'd1;
	localparam logic [1:0] ST_RELABEL = 2'd2;

	logic [1:0]         state_q;
	logic [LW-1:0]      idx_q;
	logic [LW-1:0]      cnt_q;
	logic [CLW-1:0]     a_q;
	logic [CLW-1:0]     b_q;
	logic [NW-1:0]      n_q;
	logic [LW-1:0]      la_q;
	logic [LW-1:0]      lb_q;
	logic               fa_q;
	logic               fb_q;
	logic               done_q;
	logic               acc_q;
	logic [CLW-1:0]     merged_q;
	logic               status_q;

	logic [2*CFW-1:0]   prod;
	logic [NW-1:0]      prod_x;
	logic [NW-1:0]      grid_n;
	logic               out_of_range;
	logic               hit_a;
	logic               hit_b;
	logic [LW-1:0]      la_nx;
	logic [LW-1:0]      lb_nx;
	logic               both_found;
	logic [LW-1:0]      idx_nx;
	logic               in_grid;
	logic [LW+CLW-1:0]  la_ext;

	// Grid size, capped at the ring length
	assign prod   = {{CFW{1'b0}}, grid_width} * {{CFW{1'b0}}, grid_height};
	assign prod_x = NW'(prod);
	assign grid_n = (prod_x > NW'(MAX_CELLS)) ? NW'(MAX_CELLS) : prod_x;
	assign out_of_range = (NW'(first_cell) >= grid_n) || (NW'(second_cell) >= grid_n);

	// Label capture as the ring passes the head
	assign hit_a      = (XW'(idx_q) == XW'(a_q));
	assign hit_b      = (XW'(idx_q) == XW'(b_q));
	assign la_nx      = hit_a ? head_lbl : la_q;
	assign lb_nx      = hit_b ? head_lbl : lb_q;
	assign both_found = (fa_q | hit_a) & (fb_q | hit_b);
	assign la_ext     = {{CLW{1'b0}}, la_nx};

	// Head position wraps at the ring length
	assign idx_nx  = (idx_q == LW'(MAX_CELLS - 1)) ? '0 : idx_q + 1'b1;
	assign in_grid = (NW'(idx_q) < n_q);

	// Feedback into the tail: quick-find relabel of grid cells only
	assign tail_lbl = ((state_q == ST_RELABEL) && in_grid && (head_lbl == lb_q)) ?
		la_q : head_lbl;

	assign ring_ctl.shift = (state_q == ST_FIND) || (state_q == ST_RELABEL);
	assign ring_ctl.clear = (state_q == ST_IDLE) && start && (command == cmef_pkg::CMD_CLEAR);

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign accepted     = acc_q;
	assign merged_label = merged_q;
	assign status       = status_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			cnt_q    <= '0;
			a_q      <= '0;
			b_q      <= '0;
			n_q      <= '0;
			la_q     <= '0;
			lb_q     <= '0;
			fa_q     <= 1'b0;
			fb_q     <= 1'b0;
			done_q   <= 1'b0;
			acc_q    <= 1'b0;
			merged_q <= '0;
			status_q <= cmef_pkg::STAT_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (command == cmef_pkg::CMD_CLEAR) begin
							// ring reloads in the same edge, alignment back to zero
							idx_q    <= '0;
							done_q   <= 1'b1;
							acc_q    <= 1'b0;
							merged_q <= '0;
							status_q <= cmef_pkg::STAT_OK;
						end else if (out_of_range) begin
							done_q   <= 1'b1;
							acc_q    <= 1'b0;
							merged_q <= '0;
							status_q <= cmef_pkg::STAT_RANGE;
						end else begin
							a_q     <= first_cell;
							b_q     <= second_cell;
							n_q     <= grid_n;
							fa_q    <= 1'b0;
							fb_q    <= 1'b0;
							state_q <= ST_FIND;
						end
					end
				end
				ST_FIND: begin
					idx_q <= idx_nx;
					fa_q  <= fa_q | hit_a;
					fb_q  <= fb_q | hit_b;
					la_q  <= la_nx;
					lb_q  <= lb_nx;
					if (both_found) begin
						merged_q <= la_ext[CLW-1:0];
						if (la_nx != lb_nx) begin
							cnt_q   <= '0;
							state_q <= ST_RELABEL;
						end else begin
							// same component: edge rejected
							done_q   <= 1'b1;
							acc_q    <= 1'b0;
							status_q <= cmef_pkg::STAT_OK;
							state_q  <= ST_IDLE;
						end
					end
				end
				ST_RELABEL: begin
					idx_q <= idx_nx;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LW'(MAX_CELLS - 1)) begin
						done_q   <= 1'b1;
						acc_q    <= 1'b1;
						status_q <= cmef_pkg::STAT_OK;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/component_merge_edge_filter.sv =====
// Top level: register port, ring of label cells and sequencer.
//
//  channel   | handshake         | payload
//  ----------+-------------------+------------------------------------------
//  command   | start, busy       | command, first_cell, second_cell
//  result    | done (strobe)     | accepted, merged_label, status
//  registers | psel/penable/...  | paddr, pwdata, prdata (grid_width, height)
//
// Labels sit in a ring of MAX_CELLS cells that rotates one place per cycle
// while an edge is in work. Clear and out-of-grid commands answer in the
// cycle after start. An edge takes a lookup rotation until both labels pass
// the head, then, if accepted, one full rotation that relabels at the tail.
// Reset loads every cell with its own index at once, so no clearing pass.
// Results are shown for one cycle with done.
`timescale 1ns / 1ps

module component_merge_edge_filter #(
	parameter int MAX_CELLS = cmef_pkg::MAX_CELLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// command
	input  logic                         start,
	output logic                         busy,
	input  logic                         command,
	input  logic [cmef_pkg::CELL_W-1:0]  first_cell,
	input  logic [cmef_pkg::CELL_W-1:0]  second_cell,
	// result
	output logic                         done,
	output logic                         accepted,
	output logic [cmef_pkg::CELL_W-1:0]  merged_label,
	output logic                         status
);

	localparam int LW  = $clog2(MAX_CELLS);
	localparam int CFW = cmef_pkg::CFG_W;

	logic [CFW-1:0]      grid_width_q;
	logic [CFW-1:0]      grid_height_q;
	logic                wr_en;
	logic [LW-1:0]       cell_lbl [MAX_CELLS];
	logic [LW-1:0]       tail_lbl;
	cmef_pkg::ring_ctl_t ring_ctl;

	// Register writes
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= cmef_pkg::GRID_WIDTH_RST;
			grid_height_q <= cmef_pkg::GRID_HEIGHT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				cmef_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[CFW-1:0];
				cmef_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[CFW-1:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (paddr[2])
			cmef_pkg::REG_GRID_WIDTH:  prdata = {{(32-CFW){1'b0}}, grid_width_q};
			cmef_pkg::REG_GRID_HEIGHT: prdata = {{(32-CFW){1'b0}}, grid_height_q};
			default:                   prdata = '0;
		endcase
	end

	// Ring of label cells: each takes its upper neighbor, last takes the tail
	for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
		if (i == MAX_CELLS - 1) begin : g_last
			cmef_cell #(
				.LW    (LW),
				.INDEX (i)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ring_ctl (ring_ctl),
				.lbl_in   (tail_lbl),
				.lbl_out  (cell_lbl[i])
			);
		end else begin : g_mid
			cmef_cell #(
				.LW    (LW),
				.INDEX (i)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ring_ctl (ring_ctl),
				.lbl_in   (cell_lbl[i+1]),
				.lbl_out  (cell_lbl[i])
			);
		end
	end

	// Sequencer
	cmef_ctrl #(
		.MAX_CELLS (MAX_CELLS),
		.LW        (LW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.command      (command),
		.first_cell   (first_cell),
		.second_cell  (second_cell),
		.grid_width   (grid_width_q),
		.grid_height  (grid_height_q),
		.head_lbl     (cell_lbl[0]),
		.tail_lbl     (tail_lbl),
		.ring_ctl     (ring_ctl),
		.busy         (busy),
		.done         (done),
		.accepted     (accepted),
		.merged_label (merged_label),
		.status       (status)
	);

endmodule

// ===== rtl/core/cmef_checker.sv =====
// Port-level checks for the component merge edge filter, bound to the top.
`timescale 1ns / 1ps

module cmef_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [2:0]                   paddr,
	input logic [31:0]                  pwdata,
	input logic [31:0]                  prdata,
	input logic                         start,
	input logic                         busy,
	input logic                         command,
	input logic                         done,
	input logic                         accepted,
	input logic [cmef_pkg::CELL_W-1:0]  merged_label,
	input logic                         status
);

	// A clear command answers on the next cycle with an all-zero word
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == cmef_pkg::CMD_CLEAR)) |=>
		(done && !accepted && (status == cmef_pkg::STAT_OK) && (merged_label == '0)))
		else $error("clear command did not answer with a zero word");

	// An out-of-grid word never reports a merge or a label
	a_range_word: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == cmef_pkg::STAT_RANGE)) |-> (!accepted && (merged_label == '0)))
		else $error("out-of-grid word carries a merge or label");

	// Work starts only from an accepted edge command
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && (command == cmef_pkg::CMD_EDGE)))
		else $error("busy rose without an accepted edge command");

	// No result word shows while an edge is still in work
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while busy");

	// A written grid width reads back
	a_width_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && (paddr[2] == cmef_pkg::REG_GRID_WIDTH)) ##1
		(psel && !pwrite && (paddr[2] == cmef_pkg::REG_GRID_WIDTH)) |->
		(prdata[cmef_pkg::CFG_W-1:0] == $past(pwdata[cmef_pkg::CFG_W-1:0])))
		else $error("grid width read back differs from write");

endmodule

bind component_merge_edge_filter cmef_checker u_cmef_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata),
	.start        (start),
	.busy         (busy),
	.command      (command),
	.done         (done),
	.accepted     (accepted),
	.merged_label (merged_label),
	.status       (status)
);
